// ===== sv/ncfr_pkg.sv =====
// Package for the nibble-coded frame receiver: constants, codes and the CRC-8 step.
package ncfr_pkg;

	localparam int MAX_FRAME_BYTES = 17;

	localparam logic [3:0] LINE_TAG = 4'he;

	localparam logic [7:0] HDR_B0 = 8'ha1;
	localparam logic [7:0] HDR_B1 = 8'hb3;
	localparam logic [7:0] HDR_B2 = 8'hc5;
	localparam logic [7:0] HDR_B3 = 8'hd7;

	localparam logic [7:0] CMD_QUERY   = 8'd0;
	localparam logic [7:0] CMD_SET_LIC = 8'd3;
	localparam logic [7:0] RSP_ACK     = 8'd1;
	localparam logic [7:0] RSP_DATA    = 8'd2;
	localparam logic [7:0] RSP_LIC     = 8'd4;

	localparam logic [4:0] LEN_ACK  = 5'd7;
	localparam logic [4:0] LEN_DATA = 5'd17;
	localparam logic [4:0] LEN_LIC  = 5'd15;

	localparam logic [4:0] IDX_CMD = 5'd4;
	localparam logic [4:0] IDX_CRC = 5'd5;

	localparam logic [7:0] CRC_POLY = 8'h07;

	// payload bytes 6..15 kept in a shift line, newest in the low byte
	localparam int PAY_BYTES = 10;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_CMD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEND_LIC = 1'd1;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_ACK      = 3'd1,
		EV_DATA     = 3'd2,
		EV_LIC_OK   = 3'd3,
		EV_CRC_ERR  = 3'd4,
		EV_LIC_BAD  = 3'd5
	} event_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	localparam logic [7:0] HDR_CRC =
		crc_step(crc_step(crc_step(crc_step(8'h00, HDR_B0), HDR_B1), HDR_B2), HDR_B3);

endpackage

// ===== sv/nibble_coded_frame_receiver_unit.sv =====
// Top level of the nibble-coded frame receiver.
//
// Slave stream: one raw line byte per item in s_tdata, s_tuser set marks the start of a
// new exchange and clears the nibble count before the byte is handled. Every accepted
// item yields exactly one result item on the master stream: an event code plus the
// query number, license in use and time left, the last three nonzero only on a query
// data event.
// m_tvalid rises once the item has passed the input register and the result register:
// the item lands in the input register, then the decode, running CRC-8 and license
// compare run in one pass into the result register, where it waits to be taken.
// Throughput is one item per cycle while m_tready stays high; the running CRC and the
// nibble assembly carry state from one item to the next within that single pass.
// When the receiver drops m_tready the result register holds, the input register fills,
// and s_tready falls; nothing is lost and the flow resumes the cycle m_tready returns.
// Reset clears the nibble count, frame length and both valid flags; the expected
// command resets to 255 (no frame accepted) and the pending license to zero.
// Configuration writes through cfg_we / cfg_index / cfg_wdata take effect at once and
// are meant to happen while the stream is idle.
module nibble_coded_frame_receiver_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // [7:0] raw_byte
	input  logic                                 s_tuser,   // [0] restart
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [2:0] event_res, [10:3] quest_number, [74:11] license_in_use,
	// [90:75] time_left, [95:91] zero
	output logic [95:0]                          m_tdata,
	input  logic                                 cfg_we,
	input  logic [ncfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [63:0]                          cfg_wdata
);

	localparam int PAY_W = ncfr_pkg::PAY_BYTES * 8;

	// configuration
	logic [7:0]  exp_cmd_q;
	logic [63:0] pend_lic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q  <= 8'hff;
			pend_lic_q <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				ncfr_pkg::REG_EXP_CMD:  exp_cmd_q  <= cfg_wdata[7:0];
				ncfr_pkg::REG_PEND_LIC: pend_lic_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       rst_s1;
	logic       adv;
	logic       out_vld_q;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			rst_s1  <= s_tuser;
		end
	end

	// parser state
	logic [5:0]       nc_q, nc_n;
	logic [4:0]       fl_q, fl_n;
	logic [3:0]       hi_q, hi_n;
	logic [7:0]       crc_q, crc_n;
	logic [7:0]       cmd_q, cmd_n;
	logic [7:0]       crc_rx_q, crc_rx_n;
	logic [PAY_W-1:0] pay_q, pay_n;

	logic [5:0]       nc0;
	logic [5:0]       nc_inc;
	logic [4:0]       idx;
	logic [7:0]       val;
	logic [7:0]       hdr_exp;
	ncfr_pkg::event_t ev;
	logic [7:0]       qn;
	logic [63:0]      lic;
	logic [15:0]      tl;

	always_comb begin
		nc0      = rst_s1 ? 6'd0 : nc_q;
		nc_inc   = nc0 + 6'd1;
		idx      = nc0[5:1];
		val      = {hi_q, byte_s1[3:0]};
		nc_n     = nc_q;
		fl_n     = fl_q;
		hi_n     = hi_q;
		crc_n    = crc_q;
		cmd_n    = cmd_q;
		crc_rx_n = crc_rx_q;
		pay_n    = pay_q;
		ev       = ncfr_pkg::EV_NONE;
		qn       = 8'd0;
		lic      = 64'd0;
		tl       = 16'd0;
		case (idx[1:0])
			2'd0:    hdr_exp = ncfr_pkg::HDR_B0;
			2'd1:    hdr_exp = ncfr_pkg::HDR_B1;
			2'd2:    hdr_exp = ncfr_pkg::HDR_B2;
			default: hdr_exp = ncfr_pkg::HDR_B3;
		endcase

		if (byte_s1[7:4] != ncfr_pkg::LINE_TAG) begin
			nc_n = 6'd0;
		end else if (idx >= 5'(ncfr_pkg::MAX_FRAME_BYTES)) begin
			nc_n = 6'd0;
		end else if (!nc0[0]) begin
			// first nibble of a byte: hold it
			nc_n = nc_inc;
			hi_n = byte_s1[3:0];
		end else begin
			nc_n = nc_inc;
			if (idx < ncfr_pkg::IDX_CMD) begin
				fl_n = 5'd0;
				if (val != hdr_exp) begin
					// realign: a fresh A1 restarts the header, else slip one nibble
					if (val != ncfr_pkg::HDR_B0) begin
						hi_n = val[3:0];
						nc_n = 6'd1;
					end else begin
						nc_n = 6'd2;
					end
				end
			end else if (idx == ncfr_pkg::IDX_CMD) begin
				cmd_n = val;
				crc_n = ncfr_pkg::crc_step(ncfr_pkg::HDR_CRC, val);
				if (exp_cmd_q == ncfr_pkg::CMD_QUERY && val == ncfr_pkg::RSP_ACK) begin
					fl_n = ncfr_pkg::LEN_ACK;
				end else if (exp_cmd_q == ncfr_pkg::CMD_QUERY
					&& val == ncfr_pkg::RSP_DATA) begin
					fl_n = ncfr_pkg::LEN_DATA;
				end else if (exp_cmd_q == ncfr_pkg::CMD_SET_LIC
					&& val == ncfr_pkg::RSP_LIC) begin
					fl_n = ncfr_pkg::LEN_LIC;
				end else begin
					nc_n = 6'd0;
				end
			end else begin
				// checksum byte enters the CRC as zero
				crc_n = ncfr_pkg::crc_step(crc_q, (idx == ncfr_pkg::IDX_CRC) ? 8'd0 : val);
				if (idx == ncfr_pkg::IDX_CRC) begin
					crc_rx_n = val;
				end else begin
					pay_n = {pay_q[PAY_W-9:0], val};
				end
				if (fl_q != 5'd0 && idx == fl_q - 5'd1) begin
					nc_n = 6'd0;
					if (crc_rx_q != crc_n) begin
						ev = ncfr_pkg::EV_CRC_ERR;
					end else if (cmd_q == ncfr_pkg::RSP_ACK) begin
						ev = ncfr_pkg::EV_ACK;
					end else if (cmd_q == ncfr_pkg::RSP_DATA) begin
						ev  = ncfr_pkg::EV_DATA;
						qn  = pay_q[PAY_W-1 -: 8];
						lic = pay_q[PAY_W-9 -: 64];
						tl  = {pay_q[7:0], val};
					end else if (cmd_q == ncfr_pkg::RSP_LIC) begin
						ev = (pay_q[63:0] == pend_lic_q) ? ncfr_pkg::EV_LIC_OK
							: ncfr_pkg::EV_LIC_BAD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 6'd0;
			fl_q <= 5'd0;
		end else if (adv) begin
			nc_q <= nc_n;
			fl_q <= fl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_q     <= hi_n;
			crc_q    <= crc_n;
			cmd_q    <= cmd_n;
			crc_rx_q <= crc_rx_n;
			pay_q    <= pay_n;
		end
	end

	// result register
	ncfr_pkg::event_t ev_q;
	logic [7:0]       qn_q;
	logic [63:0]      lic_q;
	logic [15:0]      tl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q  <= ev;
			qn_q  <= qn;
			lic_q <= lic;
			tl_q  <= tl;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, tl_q, lic_q, qn_q, ev_q};

endmodule

// ===== sv/ncfr_checker.sv =====
// Port-level checker for the nibble-coded frame receiver, bound to the top level.
module ncfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [95:0]                    m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side only backs up when the result register is stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_ev_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'(ncfr_pkg::EV_LIC_BAD))
		else $error("event code out of range");

	// decoded fields are zero except on a query data event
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != 3'(ncfr_pkg::EV_DATA) |-> m_tdata[95:3] == 93'd0)
		else $error("payload fields set outside a data event");

endmodule

bind nibble_coded_frame_receiver_unit ncfr_checker u_ncfr_checker (.*);
